FILE: rtl/clip_fade_gain_mix_defines.svh
// Assertion macros used by the RTL of the clip fade gain mixer.
// They expect i_clk and i_rst_n in the scope where they are used.
`ifndef CLIP_FADE_GAIN_MIX_DEFINES_SVH
`define CLIP_FADE_GAIN_MIX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFGM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFGM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cfgm_pkg.sv
`default_nettype none
package cfgm_pkg;

    localparam int LEN_WIDTH     = 24;
    localparam int GAIN_WIDTH    = 16;
    localparam int MIX_WIDTH     = 32;
    localparam int REG_IDX_WIDTH = 3;

    localparam logic [GAIN_WIDTH-1:0]       GAIN_RESET = 16'd4096;
    localparam logic signed [MIX_WIDTH-1:0] MIX_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [MIX_WIDTH-1:0] MIX_MIN    = 32'sh8000_0000;

    typedef enum logic [REG_IDX_WIDTH-1:0] {
        REG_CLIP_START     = 3'd0,
        REG_CLIP_END       = 3'd1,
        REG_FADE_IN_LEN    = 3'd2,
        REG_FADE_OUT_LEN   = 3'd3,
        REG_FADE_IN_CURVE  = 3'd4,
        REG_FADE_OUT_CURVE = 3'd5,
        REG_CLIP_GAIN      = 3'd6,
        REG_TRACK_GAIN     = 3'd7
    } t_reg_idx;

endpackage
`default_nettype wire

FILE: rtl/clip_fade_gain_mix.sv
// Clip fade gain mixer: adds one clip's scaled sample to a running mix sum.
//
// Input channel (i_in_valid / o_in_ready) carries a beat of timeline position,
// source sample and incoming mix value. Output channel (o_out_valid /
// i_out_ready) returns one beat per input beat, in order: the saturated mix,
// the inside-clip flag and the saturation flag.
//
// The datapath is a pipeline of 2*RAMP_FRAC_BITS+11 register stages (43 at
// the default widths). The depth is set by the two ramp units, each a
// bit-per-stage divider followed by a bit-per-stage square root.
// Throughput is one beat per cycle when the receiver keeps up.
//
// Every stage holds its own valid bit and advances whenever it is empty or the
// stage after it advances, so a stalled receiver only freezes the occupied
// stages; empty slots still fill, and no beat is lost or repeated.
//
// Reset clears all valid bits and loads the register defaults (unity gains,
// empty span, no fades). The configuration port may be written only while
// the pipeline is empty.
`default_nettype none
`include "clip_fade_gain_mix_defines.svh"
module clip_fade_gain_mix #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int POSITION_WIDTH = 40,
    parameter int GAIN_FRAC_BITS = 12,
    parameter int RAMP_FRAC_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [cfgm_pkg::REG_IDX_WIDTH-1:0]     i_cfg_idx,
    input  wire logic [POSITION_WIDTH-1:0]              i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [POSITION_WIDTH-1:0]              i_sample_position,
    input  wire logic signed [SAMPLE_WIDTH-1:0]         i_source_sample,
    input  wire logic signed [cfgm_pkg::MIX_WIDTH-1:0]  i_mix_in,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [cfgm_pkg::MIX_WIDTH-1:0]       o_mix_out,
    output logic                                        o_inside_clip,
    output logic                                        o_mix_saturated
);
    import cfgm_pkg::*;

    localparam int R  = RAMP_FRAC_BITS;
    // Stage where both ramps are final.
    localparam int KR = 3 + 2 * R;
    localparam int N  = KR + 8;
    // Magnitude widths after clip gain and after track gain.
    localparam int M1 = SAMPLE_WIDTH + GAIN_WIDTH - GAIN_FRAC_BITS;
    localparam int M3 = M1 + GAIN_WIDTH - GAIN_FRAC_BITS;
    localparam int WS = ((M3 > MIX_WIDTH) ? M3 : MIX_WIDTH) + 2;
    localparam logic [R:0] ONE = {1'b1, {R{1'b0}}};

    typedef struct packed {
        logic                        neg;
        logic                        in_span;
        logic [SAMPLE_WIDTH-1:0]     mag;
        logic signed [MIX_WIDTH-1:0] mix;
    } t_side;

    // Configuration registers.
    logic [POSITION_WIDTH-1:0] r_clip_start;
    logic [POSITION_WIDTH-1:0] r_clip_end;
    logic [LEN_WIDTH-1:0]      r_fin_len;
    logic [LEN_WIDTH-1:0]      r_fout_len;
    logic                      r_fin_curve;
    logic                      r_fout_curve;
    logic [GAIN_WIDTH-1:0]     r_clip_gain;
    logic [GAIN_WIDTH-1:0]     r_track_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_start <= '0;
            r_clip_end   <= '0;
            r_fin_len    <= '0;
            r_fout_len   <= '0;
            r_fin_curve  <= 1'b0;
            r_fout_curve <= 1'b0;
            r_clip_gain  <= GAIN_RESET;
            r_track_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CLIP_START:     r_clip_start <= i_cfg_data;
                REG_CLIP_END:       r_clip_end   <= i_cfg_data;
                REG_FADE_IN_LEN:    r_fin_len    <= i_cfg_data[LEN_WIDTH-1:0];
                REG_FADE_OUT_LEN:   r_fout_len   <= i_cfg_data[LEN_WIDTH-1:0];
                REG_FADE_IN_CURVE:  r_fin_curve  <= i_cfg_data[0];
                REG_FADE_OUT_CURVE: r_fout_curve <= i_cfg_data[0];
                REG_CLIP_GAIN:      r_clip_gain  <= i_cfg_data[GAIN_WIDTH-1:0];
                REG_TRACK_GAIN:     r_track_gain <= i_cfg_data[GAIN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control: a stage advances when it is empty or its successor
    // advances. The last stage is the output register.
    logic [N-1:0] r_v;
    logic [N:0]   w_en;

    assign w_en[N] = i_out_ready;
    for (genvar k = 0; k < N; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[N-1];

    // Stage 0: span test, offsets from both clip edges, sign and magnitude.
    logic [SAMPLE_WIDTH-1:0]   w_smp;
    t_side                     w_side0;
    t_side                     r_side [N-1];
    logic [POSITION_WIDTH-1:0] r_off;
    logic [POSITION_WIDTH-1:0] r_rem;

    assign w_smp = i_source_sample;

    always_comb begin
        w_side0.neg     = w_smp[SAMPLE_WIDTH-1];
        w_side0.in_span = (i_sample_position >= r_clip_start) &&
                          (i_sample_position <  r_clip_end);
        w_side0.mag     = w_smp[SAMPLE_WIDTH-1] ?
                          (~w_smp + {{(SAMPLE_WIDTH-1){1'b0}}, 1'b1}) : w_smp;
        w_side0.mix     = i_mix_in;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= w_side0;
            r_off     <= i_sample_position - r_clip_start;
            r_rem     <= r_clip_end - i_sample_position;
        end
    end

    // The side data rides along every stage up to the final sum.
    for (genvar k = 1; k < N - 1; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Stage 1: decide which fades apply. The numerators then fit the length width.
    logic                 r_act_in;
    logic                 r_act_out;
    logic [LEN_WIDTH-1:0] r_num_in;
    logic [LEN_WIDTH-1:0] r_num_out;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_act_in  <= (r_fin_len != '0) &&
                         (r_off < {{(POSITION_WIDTH-LEN_WIDTH){1'b0}}, r_fin_len});
            r_act_out <= (r_fout_len != '0) &&
                         (r_rem <= {{(POSITION_WIDTH-LEN_WIDTH){1'b0}}, r_fout_len});
            r_num_in  <= r_off[LEN_WIDTH-1:0];
            r_num_out <= r_rem[LEN_WIDTH-1:0];
        end
    end

    // Ramp units: linear ramp by division, then the equal-power root.
    logic [R:0] w_qin;
    logic [R:0] w_qout;
    logic       w_dact_in;
    logic       w_dact_out;
    logic [R:0] w_root_in;
    logic [R:0] w_root_out;
    logic [R:0] w_lin_in;
    logic [R:0] w_lin_out;
    logic       w_sact_in;
    logic       w_sact_out;

    cfgm_div #(.R(R)) u_div_in (
        .i_clk (i_clk),
        .i_en  (w_en[R+2:2]),
        .i_len (r_fin_len),
        .i_num (r_num_in),
        .i_act (r_act_in),
        .o_q   (w_qin),
        .o_act (w_dact_in)
    );

    cfgm_div #(.R(R)) u_div_out (
        .i_clk (i_clk),
        .i_en  (w_en[R+2:2]),
        .i_len (r_fout_len),
        .i_num (r_num_out),
        .i_act (r_act_out),
        .o_q   (w_qout),
        .o_act (w_dact_out)
    );

    cfgm_sqrt #(.R(R)) u_sqrt_in (
        .i_clk  (i_clk),
        .i_en   (w_en[KR:R+3]),
        .i_lin  (w_qin),
        .i_act  (w_dact_in),
        .o_root (w_root_in),
        .o_lin  (w_lin_in),
        .o_act  (w_sact_in)
    );

    cfgm_sqrt #(.R(R)) u_sqrt_out (
        .i_clk  (i_clk),
        .i_en   (w_en[KR:R+3]),
        .i_lin  (w_qout),
        .i_act  (w_dact_out),
        .o_root (w_root_out),
        .o_lin  (w_lin_out),
        .o_act  (w_sact_out)
    );

    // An inactive fade scales by exactly one, which leaves the magnitude as is.
    logic [R:0] w_fin;
    logic [R:0] w_fout;
    logic [R:0] r_fo1;
    logic [R:0] r_fo2;

    assign w_fin  = !w_sact_in  ? ONE : (r_fin_curve  ? w_root_in  : w_lin_in);
    assign w_fout = !w_sact_out ? ONE : (r_fout_curve ? w_root_out : w_lin_out);

    always_ff @(posedge i_clk) begin
        if (w_en[KR+1]) begin
            r_fo1 <= w_fout;
        end
        if (w_en[KR+2]) begin
            r_fo2 <= r_fo1;
        end
    end

    // Gain chain: clip gain, fade-in, fade-out, track gain.
    logic [M1-1:0] w_m_clip;
    logic [M1-1:0] w_m_fin;
    logic [M1-1:0] w_m_fout;
    logic [M3-1:0] w_m_trk;

    cfgm_scale #(.WM(SAMPLE_WIDTH), .WF(GAIN_WIDTH), .FRAC(GAIN_FRAC_BITS), .WO(M1))
    u_scale_clip (
        .i_clk (i_clk),
        .i_en  (w_en[KR:KR-1]),
        .i_m   (r_side[KR-2].mag),
        .i_f   (r_clip_gain),
        .o_m   (w_m_clip)
    );

    cfgm_scale #(.WM(M1), .WF(R+1), .FRAC(R), .WO(M1)) u_scale_fin (
        .i_clk (i_clk),
        .i_en  (w_en[KR+2:KR+1]),
        .i_m   (w_m_clip),
        .i_f   (w_fin),
        .o_m   (w_m_fin)
    );

    cfgm_scale #(.WM(M1), .WF(R+1), .FRAC(R), .WO(M1)) u_scale_fout (
        .i_clk (i_clk),
        .i_en  (w_en[KR+4:KR+3]),
        .i_m   (w_m_fin),
        .i_f   (r_fo2),
        .o_m   (w_m_fout)
    );

    cfgm_scale #(.WM(M1), .WF(GAIN_WIDTH), .FRAC(GAIN_FRAC_BITS), .WO(M3))
    u_scale_trk (
        .i_clk (i_clk),
        .i_en  (w_en[KR+6:KR+5]),
        .i_m   (w_m_fout),
        .i_f   (r_track_gain),
        .o_m   (w_m_trk)
    );

    // Output stage: signed contribution, saturating add to the mix.
    t_side                       w_sd;
    logic signed [WS-1:0]        w_mag_ext;
    logic signed [WS-1:0]        w_contrib;
    logic signed [WS-1:0]        w_sum;
    logic                        w_ovf;
    logic signed [MIX_WIDTH-1:0] r_mix_out;
    logic                        r_in_span;
    logic                        r_sat;

    assign w_sd      = r_side[N-2];
    assign w_mag_ext = signed'({{(WS-M3){1'b0}}, w_m_trk});
    assign w_contrib = !w_sd.in_span ? '0 : (w_sd.neg ? -w_mag_ext : w_mag_ext);
    assign w_sum     = signed'({{(WS-MIX_WIDTH){w_sd.mix[MIX_WIDTH-1]}}, w_sd.mix}) +
                       w_contrib;
    // The sum fits 32 bits only when all bits above bit 31 copy bit 31.
    assign w_ovf     = (w_sum[WS-1:MIX_WIDTH-1] != '0) &&
                       (w_sum[WS-1:MIX_WIDTH-1] != '1);

    always_ff @(posedge i_clk) begin
        if (w_en[N-1]) begin
            r_in_span <= w_sd.in_span;
            r_sat     <= w_ovf;
            if (!w_ovf) begin
                r_mix_out <= w_sum[MIX_WIDTH-1:0];
            end else if (w_sum[WS-1]) begin
                r_mix_out <= MIX_MIN;
            end else begin
                r_mix_out <= MIX_MAX;
            end
        end
    end

    assign o_mix_out       = r_mix_out;
    assign o_inside_clip   = r_in_span;
    assign o_mix_saturated = r_sat;

    `CFGM_ASSERT_NEXT(a_accept_fills, i_in_valid && o_in_ready, r_v[0], "accepted beat lost at entry")
    `CFGM_ASSERT_IMPLY(a_sat_inside, o_out_valid && o_mix_saturated, o_inside_clip, "saturation outside clip")
    `CFGM_ASSERT_IMPLY(a_sat_value, o_out_valid && o_mix_saturated, (o_mix_out == MIX_MAX) || (o_mix_out == MIX_MIN), "saturated mix not at a rail")
    `CFGM_ASSERT_IMPLY(a_ramp_bound, r_v[KR], (w_fin <= ONE) && (w_fout <= ONE), "fade ramp above unity")

endmodule
`default_nettype wire

FILE: rtl/cfgm_div.sv
`default_nettype none
// Pipelined restoring divider: q = floor(num * 2^R / len), one quotient bit per stage.
module cfgm_div #(
    parameter int R = 16
) (
    input  wire logic                            i_clk,
    input  wire logic [R:0]                      i_en,
    input  wire logic [cfgm_pkg::LEN_WIDTH-1:0]  i_len,
    input  wire logic [cfgm_pkg::LEN_WIDTH-1:0]  i_num,
    input  wire logic                            i_act,
    output logic      [R:0]                      o_q,
    output logic                                 o_act
);
    import cfgm_pkg::*;

    logic [LEN_WIDTH:0] r_p   [R+1];
    logic [R:0]         r_q   [R+1];
    logic               r_act [R+1];

    for (genvar i = 0; i <= R; i++) begin : g_stage
        localparam int B = R - i;
        logic [LEN_WIDTH:0] w_pin;
        logic [R:0]         w_qin;
        logic [R:0]         w_q;
        logic               w_actin;
        logic               w_ge;

        if (i == 0) begin : g_first
            assign w_pin   = {1'b0, i_num};
            assign w_qin   = '0;
            assign w_actin = i_act;
        end else begin : g_next
            assign w_pin   = {r_p[i-1][LEN_WIDTH-1:0], 1'b0};
            assign w_qin   = r_q[i-1];
            assign w_actin = r_act[i-1];
        end

        assign w_ge = (w_pin >= {1'b0, i_len});

        always_comb begin
            w_q    = w_qin;
            w_q[B] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[i]) begin
                r_p[i]   <= w_ge ? (w_pin - {1'b0, i_len}) : w_pin;
                r_q[i]   <= w_q;
                r_act[i] <= w_actin;
            end
        end
    end

    assign o_q   = r_q[R];
    assign o_act = r_act[R];

endmodule
`default_nettype wire

FILE: rtl/cfgm_sqrt.sv
`default_nettype none
// Pipelined digit-by-digit square root of lin * 2^R, one root bit per stage.
module cfgm_sqrt #(
    parameter int R = 16
) (
    input  wire logic       i_clk,
    input  wire logic [R:0] i_en,
    input  wire logic [R:0] i_lin,
    input  wire logic       i_act,
    output logic      [R:0] o_root,
    output logic      [R:0] o_lin,
    output logic            o_act
);
    localparam int RW = R + 4;

    logic [RW-1:0] r_rem  [R+1];
    logic [R:0]    r_root [R+1];
    logic [R:0]    r_lin  [R+1];
    logic          r_act  [R+1];

    for (genvar i = 0; i <= R; i++) begin : g_stage
        localparam int B = R - i;
        logic [RW-1:0]  w_remin;
        logic [R:0]     w_rootin;
        logic [R:0]     w_linin;
        logic           w_actin;
        logic [2*R+1:0] w_x;
        logic [RW-1:0]  w_sh;
        logic [RW-1:0]  w_trial;
        logic           w_ge;

        if (i == 0) begin : g_first
            assign w_remin  = '0;
            assign w_rootin = '0;
            assign w_linin  = i_lin;
            assign w_actin  = i_act;
        end else begin : g_next
            assign w_remin  = r_rem[i-1];
            assign w_rootin = r_root[i-1];
            assign w_linin  = r_lin[i-1];
            assign w_actin  = r_act[i-1];
        end

        assign w_x     = {1'b0, w_linin, {R{1'b0}}};
        assign w_sh    = {w_remin[RW-3:0], w_x[2*B+1 -: 2]};
        assign w_trial = {1'b0, w_rootin, 2'b01};
        assign w_ge    = (w_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en[i]) begin
                r_rem[i]  <= w_ge ? (w_sh - w_trial) : w_sh;
                r_root[i] <= {w_rootin[R-1:0], w_ge};
                r_lin[i]  <= w_linin;
                r_act[i]  <= w_actin;
            end
        end
    end

    assign o_root = r_root[R];
    assign o_lin  = r_lin[R];
    assign o_act  = r_act[R];

endmodule
`default_nettype wire

FILE: rtl/cfgm_scale.sv
`default_nettype none
// Two-stage fixed-point scaler: product, then round half up and drop FRAC bits.
module cfgm_scale #(
    parameter int WM   = 24,
    parameter int WF   = 16,
    parameter int FRAC = 12,
    parameter int WO   = 28
) (
    input  wire logic          i_clk,
    input  wire logic [1:0]    i_en,
    input  wire logic [WM-1:0] i_m,
    input  wire logic [WF-1:0] i_f,
    output logic      [WO-1:0] o_m
);
    localparam int WP = WM + WF;
    localparam logic [WP-1:0] HALF = {{(WP-1){1'b0}}, 1'b1} << (FRAC - 1);

    logic [WP-1:0] r_prod;
    logic [WO-1:0] r_out;
    logic [WP-1:0] w_sum;

    assign w_sum = r_prod + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= WP'(i_m) * WP'(i_f);
        end
        if (i_en[1]) begin
            r_out <= w_sum[FRAC +: WO];
        end
    end

    assign o_m = r_out;

endmodule
`default_nettype wire
